[rtl/awm_pkg.sv]
// Shared types, codes and constants for the affine world matrix accumulator.
// Depends on nothing; the front, sine/cosine, engine and top files refer to it by scoped names.
package awm_pkg;

   // Default configuration values for the top-level parameters.
   localparam int FRAC_BITS_DEFAULT    = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_LEN             = 24;
   localparam int QUEUE_DEPTH          = 2;

   // Angle constants in Q2.30.
   localparam logic [34:0] Q30_TWO_PI  = 35'd6746518852;
   localparam logic [34:0] Q30_PI      = 35'd3373259426;
   localparam logic [34:0] Q30_HALF_PI = 35'd1686629713;
   localparam logic [34:0] Q30_GAIN    = 35'd652032874;

   // 1/(2*pi) in Q0.32 (2^32 divided by 2*pi), rounded; estimates the number of whole turns.
   localparam logic [31:0] Q30_INV_TWO_PI = 32'd683565276;

   localparam logic signed [31:0] INT32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] INT32_MIN = 32'sh80000000;

   // Command codes of a request.
   typedef enum logic [1:0] {
      CMD_SCALE  = 2'd0,
      CMD_ROTATE = 2'd1,
      CMD_XLATE  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      cmd_type            op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } item_type;

   // Request and response of the sine/cosine unit.
   typedef struct packed {
      logic               start;
      logic signed [31:0] angle;
   } trig_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin_value;
      logic signed [31:0] cos_value;
   } trig_rsp_type;

   // Sequencer states of the matrix engine.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ANGLE,
      BK_WAIT,
      BK_MUL,
      BK_EMIT
   } back_state_type;

   // States of the sine/cosine unit.
   typedef enum logic [2:0] {
      CD_IDLE,
      CD_REDUCE,
      CD_CORRECT,
      CD_FOLD,
      CD_ROTATE,
      CD_ROUND
   } cordic_state_type;

   // Operand sources of a matrix product.
   typedef enum logic [2:0] {
      SRC_WORLD,
      SRC_TEMP,
      SRC_RZ,
      SRC_RX,
      SRC_RY,
      SRC_SCALE,
      SRC_XLATE
   } src_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'd843314857;
         5'd1:    v = 32'd497837830;
         5'd2:    v = 32'd263043837;
         5'd3:    v = 32'd133525159;
         5'd4:    v = 32'd67021687;
         5'd5:    v = 32'd33543516;
         5'd6:    v = 32'd16775850;
         5'd7:    v = 32'd8388437;
         5'd8:    v = 32'd4194283;
         5'd9:    v = 32'd2097149;
         5'd10:   v = 32'd1048576;
         5'd11:   v = 32'd524288;
         5'd12:   v = 32'd262144;
         5'd13:   v = 32'd131072;
         5'd14:   v = 32'd65536;
         5'd15:   v = 32'd32768;
         5'd16:   v = 32'd16384;
         5'd17:   v = 32'd8192;
         5'd18:   v = 32'd4096;
         5'd19:   v = 32'd2048;
         5'd20:   v = 32'd1024;
         5'd21:   v = 32'd512;
         5'd22:   v = 32'd256;
         5'd23:   v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   // Negation that saturates the most negative value.
   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == INT32_MIN) begin
         r = INT32_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

[rtl/awm_if.sv]
// Valid/ready channel interfaces for requests and row responses.
// Depends on nothing; used by the top level and the front and back modules.
interface awm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] x_value;
   logic signed [31:0] y_value;
   logic signed [31:0] z_value;

   modport source (output valid, command, x_value, y_value, z_value, input ready);
   modport sink   (input valid, command, x_value, y_value, z_value, output ready);
endinterface

interface awm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row_index;
   logic signed [31:0] col0;
   logic signed [31:0] col1;
   logic signed [31:0] col2;
   logic signed [31:0] col3;
   logic               last_row;

   modport source (output valid, row_index, col0, col1, col2, col3, last_row,
                   input ready);
   modport sink   (input valid, row_index, col0, col1, col2, col3, last_row,
                   output ready);
endinterface

[rtl/awm_front.sv]
// Request front end: accepts requests, classifies the command and queues them.
// Depends on awm_pkg and awm_req_if.
module awm_front (
   input  logic             clock,
   input  logic             reset,
   awm_req_if.sink          req_chan,
   output logic             item_valid,
   input  logic             item_ready,
   output awm_pkg::item_type item
);

   localparam int PW = $clog2(awm_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(awm_pkg::QUEUE_DEPTH + 1);

   awm_pkg::item_type queue_ff [awm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;
   awm_pkg::item_type new_item;

   // Classify the incoming request.
   always_comb begin
      new_item.op = awm_pkg::cmd_type'(req_chan.command);
      new_item.x  = req_chan.x_value;
      new_item.y  = req_chan.y_value;
      new_item.z  = req_chan.z_value;
   end

   assign req_chan.ready = (count_ff != CW'(awm_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign pop            = item_valid && item_ready;
   assign item           = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(awm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(awm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/awm_cordic.sv]
// Iterative sine/cosine unit: range reduction by a reciprocal estimate of whole
// turns with a compare-and-subtract correction, a fold into [-pi/2, pi/2] and
// rotation-mode CORDIC steps. Depends on awm_pkg.
module awm_cordic #(
   parameter int FRAC_BITS    = awm_pkg::FRAC_BITS_DEFAULT,
   parameter int CORDIC_STEPS = awm_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  awm_pkg::trig_req_type trig_req,
   output awm_pkg::trig_rsp_type trig_rsp
);

   localparam int SH    = 30 - FRAC_BITS;
   localparam int ZW    = 62 - FRAC_BITS;
   localparam int RW    = ZW + 1;
   localparam int QW    = 24;
   localparam int NSTEP = (CORDIC_STEPS > awm_pkg::ATAN_LEN) ? awm_pkg::ATAN_LEN
                                                             : CORDIC_STEPS;
   localparam logic signed [RW-1:0] TWO_PI_R = RW'(awm_pkg::Q30_TWO_PI);
   localparam logic signed [35:0] HALF = 36'sd1 <<< (SH - 1);

   awm_pkg::cordic_state_type state_ff, state_in;

   logic signed [RW-1:0] rem_ff;
   logic signed [QW-1:0] turns_ff;
   logic [4:0]         step_ff;
   logic signed [35:0] z_ff;
   logic signed [33:0] x_ff, y_ff;
   logic               neg_ff;
   logic               done_ff;
   logic signed [31:0] sin_ff, cos_ff;

   logic signed [ZW-1:0] z_start;
   logic signed [63:0]   turns_prod;
   logic signed [RW-1:0] turns_mult;
   logic signed [35:0]   z_wrap, z_fold;
   logic                 fold_neg;
   logic signed [33:0]   xs, ys;
   logic signed [35:0]   atan_s;
   logic signed [35:0]   x_fin, y_fin;

   // Angle moved to Q2.30.
   assign z_start = ZW'(trig_req.angle) <<< SH;

   // Estimated whole turns of the angle and the matching multiple of 2*pi.
   assign turns_prod = 64'(trig_req.angle) * $signed(64'(awm_pkg::Q30_INV_TWO_PI));
   assign turns_mult = RW'(turns_ff) * TWO_PI_R;

   // Wrap into [-pi, pi), then fold into [-pi/2, pi/2].
   always_comb begin
      z_wrap   = $signed({2'b00, rem_ff[33:0]});
      if (rem_ff[33:0] >= 34'(awm_pkg::Q30_PI)) begin
         z_wrap = z_wrap - $signed({1'b0, awm_pkg::Q30_TWO_PI});
      end
      z_fold   = z_wrap;
      fold_neg = 1'b0;
      if (z_wrap > $signed({1'b0, awm_pkg::Q30_HALF_PI})) begin
         z_fold   = z_wrap - $signed({1'b0, awm_pkg::Q30_PI});
         fold_neg = 1'b1;
      end else if (z_wrap < -$signed({1'b0, awm_pkg::Q30_HALF_PI})) begin
         z_fold   = z_wrap + $signed({1'b0, awm_pkg::Q30_PI});
         fold_neg = 1'b1;
      end
   end

   // One rotation step operands.
   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign atan_s = $signed({4'b0000, awm_pkg::atan_q30(step_ff)});

   // Final sign and rounding.
   always_comb begin
      x_fin = neg_ff ? -36'(x_ff) : 36'(x_ff);
      y_fin = neg_ff ? -36'(y_ff) : 36'(y_ff);
      x_fin = (x_fin + HALF) >>> SH;
      y_fin = (y_fin + HALF) >>> SH;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         awm_pkg::CD_IDLE: begin
            if (trig_req.start) begin
               state_in = awm_pkg::CD_REDUCE;
            end
         end
         awm_pkg::CD_REDUCE: begin
            state_in = awm_pkg::CD_CORRECT;
         end
         awm_pkg::CD_CORRECT: begin
            if (!rem_ff[RW-1] && rem_ff < TWO_PI_R) begin
               state_in = awm_pkg::CD_FOLD;
            end
         end
         awm_pkg::CD_FOLD: begin
            state_in = awm_pkg::CD_ROTATE;
         end
         awm_pkg::CD_ROTATE: begin
            if (step_ff == 5'(NSTEP - 1)) begin
               state_in = awm_pkg::CD_ROUND;
            end
         end
         awm_pkg::CD_ROUND: begin
            state_in = awm_pkg::CD_IDLE;
         end
         default: begin
            state_in = awm_pkg::CD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= awm_pkg::CD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == awm_pkg::CD_ROUND);
      end
   end

   // Datapath registers, one step per cycle.
   always_ff @(posedge clock) begin
      case (state_ff)
         awm_pkg::CD_IDLE: begin
            rem_ff   <= RW'(z_start);
            turns_ff <= QW'(turns_prod >>> (32 + FRAC_BITS));
         end
         awm_pkg::CD_REDUCE: begin
            rem_ff <= rem_ff - turns_mult;
         end
         awm_pkg::CD_CORRECT: begin
            // The estimate can be off by a turn; step the remainder into [0, 2*pi).
            if (rem_ff[RW-1]) begin
               rem_ff <= rem_ff + TWO_PI_R;
            end else if (rem_ff >= TWO_PI_R) begin
               rem_ff <= rem_ff - TWO_PI_R;
            end
         end
         awm_pkg::CD_FOLD: begin
            z_ff    <= z_fold;
            neg_ff  <= fold_neg;
            x_ff    <= 34'(awm_pkg::Q30_GAIN);
            y_ff    <= '0;
            step_ff <= '0;
         end
         awm_pkg::CD_ROTATE: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_s;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_s;
            end
            step_ff <= step_ff + 1'b1;
         end
         awm_pkg::CD_ROUND: begin
            if (x_fin > 36'(awm_pkg::INT32_MAX)) begin
               cos_ff <= awm_pkg::INT32_MAX;
            end else if (x_fin < 36'(awm_pkg::INT32_MIN)) begin
               cos_ff <= awm_pkg::INT32_MIN;
            end else begin
               cos_ff <= x_fin[31:0];
            end
            if (y_fin > 36'(awm_pkg::INT32_MAX)) begin
               sin_ff <= awm_pkg::INT32_MAX;
            end else if (y_fin < 36'(awm_pkg::INT32_MIN)) begin
               sin_ff <= awm_pkg::INT32_MIN;
            end else begin
               sin_ff <= y_fin[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Response outputs.
   always_comb begin
      trig_rsp.done      = done_ff;
      trig_rsp.sin_value = sin_ff;
      trig_rsp.cos_value = cos_ff;
   end

   // A start is only issued while the unit is idle.
   assert property (@(posedge clock) disable iff (reset)
      trig_req.start |-> state_ff == awm_pkg::CD_IDLE)
      else $error("trig start while busy");

   // A result follows in the cycle after the rounding step.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == awm_pkg::CD_ROUND |=> done_ff)
      else $error("trig done missing");

   // The reduction leaves a remainder in [0, 2*pi).
   assert property (@(posedge clock) disable iff (reset)
      state_ff == awm_pkg::CD_FOLD |-> (!rem_ff[RW-1] && rem_ff < TWO_PI_R))
      else $error("angle reduction out of range");

endmodule

[rtl/awm_back.sv]
// Matrix engine: builds the transform, multiplies through one shared 32x32
// multiplier, keeps the world matrix and emits its rows. Depends on awm_pkg, awm_rsp_if.
module awm_back #(
   parameter int FRAC_BITS = awm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  awm_pkg::item_type     item,
   output awm_pkg::trig_req_type trig_req,
   input  awm_pkg::trig_rsp_type trig_rsp,
   awm_rsp_if.source             rsp_chan
);

   localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   awm_pkg::back_state_type state_ff, state_in;

   // Current request.
   awm_pkg::cmd_type   op_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [1:0]         ang_ff;
   logic signed [31:0] sin_ff [3];
   logic signed [31:0] cos_ff [3];

   // Matrices.
   logic signed [31:0] w_ff [16];
   logic signed [31:0] t_ff [16];
   logic signed [31:0] rowbuf_ff [3];

   // Product sequencing and pipeline.
   logic [1:0]         pass_ff;
   logic               issue_ff;
   logic [5:0]         idx_ff;
   logic               s1_v_ff, s2_v_ff, s3_v_ff;
   logic [5:0]         s1_tag_ff, s2_tag_ff;
   logic [3:0]         s3_tag_ff;
   logic signed [31:0] opa_ff, opb_ff;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;

   // Output register.
   logic [1:0]         row_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_row_ff;
   logic signed [31:0] rsp_col_ff [4];
   logic               rsp_last_ff;

   awm_pkg::src_type   a_src, b_src;
   logic [3:0]         a_idx, b_idx;
   logic signed [31:0] a_val, b_val;
   logic signed [65:0] rnd;
   logic signed [31:0] rnd_val;
   logic               pass_done;
   logic               rsp_load;
   logic               dest_world;

   // Element of a built transform matrix, row-major index.
   function automatic logic signed [31:0] gen_elem(
      input awm_pkg::src_type   src,
      input logic [3:0]         idx,
      input logic signed [31:0] gx, gy, gz,
      input logic signed [31:0] sx, cx, sy, cy, sz, cz
   );
      logic signed [31:0] v;
      v = '0;
      case (src)
         awm_pkg::SRC_RZ: begin
            case (idx)
               4'd0, 4'd5:   v = cz;
               4'd1:         v = sz;
               4'd4:         v = awm_pkg::neg_sat(sz);
               4'd10, 4'd15: v = ONE;
               default:      v = '0;
            endcase
         end
         awm_pkg::SRC_RX: begin
            case (idx)
               4'd5, 4'd10: v = cx;
               4'd6:        v = sx;
               4'd9:        v = awm_pkg::neg_sat(sx);
               4'd0, 4'd15: v = ONE;
               default:     v = '0;
            endcase
         end
         awm_pkg::SRC_RY: begin
            case (idx)
               4'd0, 4'd10: v = cy;
               4'd2:        v = awm_pkg::neg_sat(sy);
               4'd8:        v = sy;
               4'd5, 4'd15: v = ONE;
               default:     v = '0;
            endcase
         end
         awm_pkg::SRC_SCALE: begin
            case (idx)
               4'd0:    v = gx;
               4'd5:    v = gy;
               4'd10:   v = gz;
               4'd15:   v = ONE;
               default: v = '0;
            endcase
         end
         awm_pkg::SRC_XLATE: begin
            case (idx)
               4'd0, 4'd5, 4'd10, 4'd15: v = ONE;
               4'd12:   v = gx;
               4'd13:   v = gy;
               4'd14:   v = gz;
               default: v = '0;
            endcase
         end
         default: begin
            v = '0;
         end
      endcase
      return v;
   endfunction

   // Operand sources of the current pass: Rz*Rx, then *Ry, then world*M.
   always_comb begin
      dest_world = (pass_ff == 2'd2);
      case (pass_ff)
         2'd0: begin
            a_src = awm_pkg::SRC_RZ;
            b_src = awm_pkg::SRC_RX;
         end
         2'd1: begin
            a_src = awm_pkg::SRC_TEMP;
            b_src = awm_pkg::SRC_RY;
         end
         default: begin
            a_src = awm_pkg::SRC_WORLD;
            case (op_ff)
               awm_pkg::CMD_SCALE:  b_src = awm_pkg::SRC_SCALE;
               awm_pkg::CMD_ROTATE: b_src = awm_pkg::SRC_TEMP;
               default:             b_src = awm_pkg::SRC_XLATE;
            endcase
         end
      endcase
   end

   // Operand fetch: idx is {row, column, term}.
   assign a_idx = {idx_ff[5:4], idx_ff[1:0]};
   assign b_idx = {idx_ff[1:0], idx_ff[3:2]};

   always_comb begin
      case (a_src)
         awm_pkg::SRC_WORLD: a_val = w_ff[a_idx];
         awm_pkg::SRC_TEMP:  a_val = t_ff[a_idx];
         default: a_val = gen_elem(a_src, a_idx, x_ff, y_ff, z_ff, sin_ff[0], cos_ff[0],
                                   sin_ff[1], cos_ff[1], sin_ff[2], cos_ff[2]);
      endcase
      case (b_src)
         awm_pkg::SRC_WORLD: b_val = w_ff[b_idx];
         awm_pkg::SRC_TEMP:  b_val = t_ff[b_idx];
         default: b_val = gen_elem(b_src, b_idx, x_ff, y_ff, z_ff, sin_ff[0], cos_ff[0],
                                   sin_ff[1], cos_ff[1], sin_ff[2], cos_ff[2]);
      endcase
   end

   // Round to nearest, ties up, and saturate the finished sum.
   always_comb begin
      rnd = (acc_ff + HALF) >>> FRAC_BITS;
      if (rnd > 66'(awm_pkg::INT32_MAX)) begin
         rnd_val = awm_pkg::INT32_MAX;
      end else if (rnd < 66'(awm_pkg::INT32_MIN)) begin
         rnd_val = awm_pkg::INT32_MIN;
      end else begin
         rnd_val = rnd[31:0];
      end
   end

   assign pass_done = !issue_ff && !s1_v_ff && !s2_v_ff && !s3_v_ff;
   assign rsp_load  = (state_ff == awm_pkg::BK_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         awm_pkg::BK_IDLE: begin
            if (item_valid) begin
               case (item.op)
                  awm_pkg::CMD_ROTATE: state_in = awm_pkg::BK_ANGLE;
                  awm_pkg::CMD_NONE:   state_in = awm_pkg::BK_EMIT;
                  default:             state_in = awm_pkg::BK_MUL;
               endcase
            end
         end
         awm_pkg::BK_ANGLE: begin
            state_in = awm_pkg::BK_WAIT;
         end
         awm_pkg::BK_WAIT: begin
            if (trig_rsp.done) begin
               state_in = (ang_ff == 2'd2) ? awm_pkg::BK_MUL : awm_pkg::BK_ANGLE;
            end
         end
         awm_pkg::BK_MUL: begin
            if (pass_done && dest_world) begin
               state_in = awm_pkg::BK_EMIT;
            end
         end
         awm_pkg::BK_EMIT: begin
            if (rsp_load && row_ff == 2'd3) begin
               state_in = awm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = awm_pkg::BK_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      item_ready     = (state_ff == awm_pkg::BK_IDLE);
      trig_req.start = (state_ff == awm_pkg::BK_ANGLE);
      case (ang_ff)
         2'd0:    trig_req.angle = x_ff;
         2'd1:    trig_req.angle = y_ff;
         default: trig_req.angle = z_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awm_pkg::BK_IDLE;
         issue_ff     <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 2'd0;
         ang_ff       <= 2'd0;
         row_ff       <= 2'd0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == awm_pkg::BK_IDLE && item_valid) begin
            ang_ff  <= 2'd0;
            row_ff  <= 2'd0;
            idx_ff  <= '0;
            pass_ff <= (item.op == awm_pkg::CMD_ROTATE) ? 2'd0 : 2'd2;
            issue_ff <= (item.op == awm_pkg::CMD_SCALE) || (item.op == awm_pkg::CMD_XLATE);
         end
         if (state_ff == awm_pkg::BK_WAIT && trig_rsp.done) begin
            ang_ff <= ang_ff + 1'b1;
            if (ang_ff == 2'd2) begin
               issue_ff <= 1'b1;
            end
         end
         // Issue one product term per cycle.
         if (issue_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == 6'd63) begin
               issue_ff <= 1'b0;
            end
         end
         if (state_ff == awm_pkg::BK_MUL && pass_done && !dest_world) begin
            pass_ff  <= pass_ff + 1'b1;
            issue_ff <= 1'b1;
         end
         s1_v_ff <= issue_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && (s2_tag_ff[1:0] == 2'd3);
         // Output register.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            row_ff       <= row_ff + 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture and sine/cosine results.
   always_ff @(posedge clock) begin
      if (state_ff == awm_pkg::BK_IDLE && item_valid) begin
         op_ff <= item.op;
         x_ff  <= item.x;
         y_ff  <= item.y;
         z_ff  <= item.z;
      end
      if (state_ff == awm_pkg::BK_WAIT && trig_rsp.done) begin
         sin_ff[ang_ff] <= trig_rsp.sin_value;
         cos_ff[ang_ff] <= trig_rsp.cos_value;
      end
   end

   // Multiply and accumulate pipeline.
   always_ff @(posedge clock) begin
      opa_ff    <= a_val;
      opb_ff    <= b_val;
      s1_tag_ff <= idx_ff;
      prod_ff   <= opa_ff * opb_ff;
      s2_tag_ff <= s1_tag_ff;
      if (s2_v_ff) begin
         acc_ff    <= ((s2_tag_ff[1:0] == 2'd0) ? 66'sd0 : acc_ff) + 66'(prod_ff);
         s3_tag_ff <= s2_tag_ff[5:2];
      end
   end

   // Row buffer and scratch matrix; a row is committed once its last element is done.
   always_ff @(posedge clock) begin
      if (s3_v_ff) begin
         if (s3_tag_ff[1:0] != 2'd3) begin
            rowbuf_ff[s3_tag_ff[1:0]] <= rnd_val;
         end else if (!dest_world) begin
            t_ff[{s3_tag_ff[3:2], 2'd0}] <= rowbuf_ff[0];
            t_ff[{s3_tag_ff[3:2], 2'd1}] <= rowbuf_ff[1];
            t_ff[{s3_tag_ff[3:2], 2'd2}] <= rowbuf_ff[2];
            t_ff[{s3_tag_ff[3:2], 2'd3}] <= rnd_val;
         end
      end
   end

   // World matrix, identity after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < 16; e++) begin
            w_ff[e] <= ((e % 5) == 0) ? ONE : 32'sd0;
         end
      end else if (s3_v_ff && s3_tag_ff[1:0] == 2'd3 && dest_world) begin
         w_ff[{s3_tag_ff[3:2], 2'd0}] <= rowbuf_ff[0];
         w_ff[{s3_tag_ff[3:2], 2'd1}] <= rowbuf_ff[1];
         w_ff[{s3_tag_ff[3:2], 2'd2}] <= rowbuf_ff[2];
         w_ff[{s3_tag_ff[3:2], 2'd3}] <= rnd_val;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff    <= row_ff;
         rsp_last_ff   <= (row_ff == 2'd3);
         rsp_col_ff[0] <= w_ff[{row_ff, 2'd0}];
         rsp_col_ff[1] <= w_ff[{row_ff, 2'd1}];
         rsp_col_ff[2] <= w_ff[{row_ff, 2'd2}];
         rsp_col_ff[3] <= w_ff[{row_ff, 2'd3}];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.row_index = rsp_row_ff;
   assign rsp_chan.col0      = rsp_col_ff[0];
   assign rsp_chan.col1      = rsp_col_ff[1];
   assign rsp_chan.col2      = rsp_col_ff[2];
   assign rsp_chan.col3      = rsp_col_ff[3];
   assign rsp_chan.last_row  = rsp_last_ff;

   // The last-row flag marks row three and nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_row_ff == 2'd3)))
      else $error("last_row flag mismatch");

   // Finished elements appear only while a product pass runs.
   assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> state_ff == awm_pkg::BK_MUL)
      else $error("element finished outside a product pass");

   // Sine/cosine results arrive only while the engine waits for them.
   assert property (@(posedge clock) disable iff (reset)
      trig_rsp.done |-> state_ff == awm_pkg::BK_WAIT)
      else $error("unexpected sine/cosine result");

endmodule

[rtl/affine_world_matrix_accumulator.sv]
// Affine world matrix accumulator: a 4x4 Q16.16 world matrix updated by scale,
// rotate and translate requests. Channels: req_chan (command, x_value, y_value,
// z_value) and rsp_chan (row_index, col0..col3, last_row), both valid/ready;
// a transfer happens on a rising edge with valid and ready high.
// Each request yields four responses, rows 0 to 3, the last flagged by last_row.
// A front queue of two entries takes requests while the engine works; the
// engine handles one request at a time.
// Scale and translate take one product pass through the multiplier pipeline and
// the sequencing, then the four rows are emitted.
// Rotate first runs three sine/cosine evaluations, each with a whole-turn
// estimate and its correction, the fold, one CORDIC step a cycle and the
// rounding, then three product passes.
// The rate is set by the single shared 32x32 multiplier and the iterative
// sine/cosine unit. An unused command only emits the current rows.
// Reset (synchronous, active high) loads the identity matrix and empties the
// queue. When the receiver stalls, the row stays in the output register and
// the engine waits; requests keep queuing until the front queue is full.
// Depends on awm_pkg, awm_if, awm_front, awm_cordic and awm_back.
module affine_world_matrix_accumulator #(
   parameter int FRAC_BITS    = awm_pkg::FRAC_BITS_DEFAULT,
   parameter int CORDIC_STEPS = awm_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   awm_req_if.sink   req_chan,
   awm_rsp_if.source rsp_chan
);

   logic                  item_valid;
   logic                  item_ready;
   awm_pkg::item_type     item;
   awm_pkg::trig_req_type trig_req;
   awm_pkg::trig_rsp_type trig_rsp;

   // Request queue.
   awm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // Sine/cosine unit.
   awm_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .trig_req (trig_req),
      .trig_rsp (trig_rsp)
   );

   // Matrix engine.
   awm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .trig_req   (trig_req),
      .trig_rsp   (trig_rsp),
      .rsp_chan   (rsp_chan)
   );

endmodule
